FILE: design/key_value_hex_line_parser_top_defines.svh
// ----------------------------------------------------------------------------
// key_value_hex_line_parser_top_defines.svh
// Assertion macros for the key/value hex line parser.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_HEX_LINE_PARSER_TOP_DEFINES_SVH
`define KEY_VALUE_HEX_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define KLP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define KLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/klp_pkg.sv
// ----------------------------------------------------------------------------
// klp_pkg
// Types and character constants shared by the line parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package klp_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_LEAD  = 3'd1,
      PH_KEY   = 3'd2,
      PH_KEYWS = 3'd3,
      PH_VALWS = 3'd4,
      PH_VALUE = 3'd5,
      PH_TRAIL = 3'd6,
      PH_DROP  = 3'd7
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK     = 4'd0,
      ST_EMPTY  = 4'd1,
      ST_UNTERM = 4'd2,
      ST_BADKEY = 4'd3,
      ST_NOSEP  = 4'd4,
      ST_NOKEY  = 4'd5,
      ST_BADHEX = 4'd6,
      ST_TRAIL  = 4'd7,
      ST_BADLEN = 4'd8,
      ST_EOF    = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_EQ         = 8'h3D;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_0          = 8'h30;
   localparam logic [7:0] CHAR_9          = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_OFFSET     = 8'h20;
   localparam logic [3:0] HEX_TEN         = 4'hA;
   localparam logic [7:0] LEN_MAX         = 8'hFF;

   typedef struct packed {
      logic       action;
      logic [7:0] text_byte;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      status_type status;
      logic [7:0] key_length;
      logic [7:0] value_length;
   } result_type;

endpackage

FILE: design/klp_in_stage.sv
// ----------------------------------------------------------------------------
// klp_in_stage
// Input register: holds one accepted byte until the parser core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  klp_pkg::item_type in_item,
   output logic              item_valid,
   output klp_pkg::item_type item,
   input  logic              item_take
);
   import klp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready = !valid_ff || item_take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: design/klp_core.sv
// ----------------------------------------------------------------------------
// klp_core
// Line state and per-byte decode: key folding, hex pairing, line status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klp_core #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  klp_pkg::item_type   item,
   output logic                item_take,
   input  logic                out_can_load,
   output logic                result_valid,
   output klp_pkg::result_type result
);
   import klp_pkg::*;

   localparam int SHOW_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

   phase_type              phase_ff, phase_in;
   status_type             error_ff, error_in;
   logic [COUNT_WIDTH-1:0] key_total_ff, key_total_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic                   pending_ff, pending_in;
   logic [3:0]             high_ff, high_in;

   logic [7:0]            c;
   logic                  is_text, is_cr, is_lf, is_blank, is_sep;
   logic [7:0]            low_char;
   logic                  key_ok, hex_ok;
   logic [3:0]            hex_nib;
   status_type            line_st;
   logic [SHOW_WIDTH-1:0] key_wide, byte_wide;
   logic [7:0]            key_shown, byte_shown;
   logic                  key_phase, hex_phase, no_error;
   logic                  key_emit, hex_emit;

   assign c        = item.text_byte;
   assign is_text  = !item.action;
   assign is_cr    = (c == CHAR_CR);
   assign is_lf    = (c == CHAR_LF);
   assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign is_sep   = (c == CHAR_EQ) || (c == CHAR_COMMA);

   assign low_char = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
   assign key_ok   = (low_char == CHAR_UNDERSCORE)
                  || ((low_char >= CHAR_0) && (low_char <= CHAR_9))
                  || ((low_char >= CHAR_LOWER_A) && (low_char <= CHAR_LOWER_Z));

   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = c[3:0];
      priority if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         hex_nib = c[3:0];
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         hex_nib = 4'(c - CHAR_LOWER_A) + HEX_TEN;
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         hex_nib = 4'(c - CHAR_UPPER_A) + HEX_TEN;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Status the pending line would carry if it ended on this byte.
   always_comb begin
      line_st = ST_OK;
      if (error_ff != ST_OK) begin
         line_st = error_ff;
      end else begin
         unique case (phase_ff)
            PH_START:         line_st = ST_EMPTY;
            PH_LEAD, PH_KEY:  line_st = ST_UNTERM;
            PH_KEYWS:         line_st = ST_NOSEP;
            PH_VALWS:         line_st = ST_BADLEN;
            default:          line_st = pending_ff ? ST_BADLEN : ST_OK;
         endcase
      end
   end

   assign key_wide   = SHOW_WIDTH'(key_total_ff);
   assign byte_wide  = SHOW_WIDTH'(byte_count_ff);
   assign key_shown  = (key_wide > SHOW_WIDTH'(LEN_MAX)) ? LEN_MAX : key_wide[7:0];
   assign byte_shown = (byte_wide > SHOW_WIDTH'(LEN_MAX)) ? LEN_MAX : byte_wide[7:0];

   assign key_phase = (phase_ff == PH_START) || (phase_ff == PH_LEAD) || (phase_ff == PH_KEY);
   assign hex_phase = (phase_ff == PH_VALWS) || (phase_ff == PH_VALUE);
   assign no_error  = (error_ff == ST_OK);
   assign key_emit  = key_phase && !is_blank && !is_sep && key_ok;
   assign hex_emit  = hex_phase && !is_blank && hex_ok && pending_ff;

   // Result for the byte in the input register
   always_comb begin
      result_valid        = 1'b0;
      result.kind         = KIND_KEY;
      result.data         = 8'd0;
      result.status       = ST_OK;
      result.key_length   = 8'd0;
      result.value_length = 8'd0;
      priority if (!is_text) begin
         result_valid = 1'b1;
         result.kind  = KIND_STATUS;
         if ((phase_ff == PH_START) || (phase_ff == PH_DROP)) begin
            result.status = ST_EOF;
         end else begin
            result.status       = line_st;
            result.key_length   = key_shown;
            result.value_length = byte_shown;
         end
      end else if (phase_ff == PH_DROP) begin
         result_valid = 1'b0;
      end else if (is_cr || is_lf) begin
         result_valid        = 1'b1;
         result.kind         = KIND_STATUS;
         result.status       = line_st;
         result.key_length   = key_shown;
         result.value_length = byte_shown;
      end else if (no_error && key_emit) begin
         result_valid = 1'b1;
         result.kind  = KIND_KEY;
         result.data  = low_char;
      end else if (no_error && hex_emit) begin
         result_valid = 1'b1;
         result.kind  = KIND_VALUE;
         result.data  = {high_ff, hex_nib};
      end else begin
         result_valid = 1'b0;
      end
   end

   // A byte with a result waits for room in the output register.
   assign item_take = item_valid && (!result_valid || out_can_load);

   // Next line state
   always_comb begin
      phase_in      = phase_ff;
      error_in      = error_ff;
      key_total_in  = key_total_ff;
      byte_count_in = byte_count_ff;
      pending_in    = pending_ff;
      high_in       = high_ff;
      if (item_take) begin
         // while dropping, only LF or an end-of-file marker ends the line; a CR there is dropped too
         priority if (!is_text || (phase_ff == PH_DROP && is_lf)
                      || (phase_ff != PH_DROP && (is_cr || is_lf))) begin
            phase_in      = (is_text && is_cr) ? PH_DROP : PH_START;
            error_in      = ST_OK;
            key_total_in  = '0;
            byte_count_in = '0;
            pending_in    = 1'b0;
            high_in       = 4'd0;
         end else if (phase_ff == PH_DROP || !no_error) begin
            phase_in = phase_ff;
         end else begin
            unique case (phase_ff)
               PH_START, PH_LEAD, PH_KEY: begin
                  if (is_blank) begin
                     phase_in = (phase_ff == PH_KEY) ? PH_KEYWS : PH_LEAD;
                  end else if (is_sep) begin
                     if (phase_ff == PH_KEY) begin
                        phase_in = PH_VALWS;
                     end else begin
                        phase_in = PH_LEAD;
                        error_in = ST_NOKEY;
                     end
                  end else if (key_ok) begin
                     phase_in = PH_KEY;
                     if (key_total_ff != '1) begin
                        key_total_in = key_total_ff + COUNT_WIDTH'(1);
                     end
                  end else begin
                     // bad key char keeps the line in the lead phase if no key yet
                     phase_in = (phase_ff == PH_KEY) ? PH_KEY : PH_LEAD;
                     error_in = ST_BADKEY;
                  end
               end
               PH_KEYWS: begin
                  if (is_sep) begin
                     phase_in = PH_VALWS;
                  end else if (!is_blank) begin
                     error_in = ST_NOSEP;
                  end
               end
               PH_VALWS, PH_VALUE: begin
                  if (is_blank) begin
                     phase_in = (phase_ff == PH_VALUE) ? PH_TRAIL : PH_VALWS;
                  end else if (hex_ok) begin
                     phase_in   = PH_VALUE;
                     pending_in = !pending_ff;
                     if (!pending_ff) begin
                        high_in = hex_nib;
                     end else if (byte_count_ff != '1) begin
                        byte_count_in = byte_count_ff + COUNT_WIDTH'(1);
                     end
                  end else begin
                     error_in = ST_BADHEX;
                  end
               end
               default: begin
                  if (!is_blank) begin
                     error_in = ST_TRAIL;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         error_ff      <= ST_OK;
         key_total_ff  <= '0;
         byte_count_ff <= '0;
         pending_ff    <= 1'b0;
         high_ff       <= 4'd0;
      end else begin
         phase_ff      <= phase_in;
         error_ff      <= error_in;
         key_total_ff  <= key_total_in;
         byte_count_ff <= byte_count_in;
         pending_ff    <= pending_in;
         high_ff       <= high_in;
      end
   end

endmodule

FILE: design/klp_out_stage.sv
// ----------------------------------------------------------------------------
// klp_out_stage
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  klp_pkg::result_type load_result,
   output logic                can_load,
   output logic                out_valid,
   input  logic                out_ready,
   output klp_pkg::result_type out_result
);
   import klp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

FILE: design/key_value_hex_line_parser_top.sv
// ----------------------------------------------------------------------------
// key_value_hex_line_parser_top
// Streaming checker for "key = hexvalue" text lines, one byte per transfer.
//
// req_ channel: one text byte (req_action = 0) or an end-of-file marker
//   (req_action = 1) per transfer. rsp_ channel: at most one result per input
//   transfer: a lower-cased key character, a decoded value byte (on the second
//   hex digit of a pair), or a line/file status with key and value counts.
// Order: an accepted byte is registered in the input register, then the core
//   decode loads its result into the result register, which drives the rsp_
//   channel.
// Throughput: one byte per cycle when no stall (below) holds a byte; the input
//   and result registers overlap with the core's line state update.
// Stall: while the result register is full and rsp_ready is low, a byte that
//   produces a result waits in the input register and req_ready drops; bytes
//   that produce no result still drain.
// Reset: synchronous; clears both registers' valid flags and the line state
//   to line start. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_value_hex_line_parser_top_defines.svh"

module key_value_hex_line_parser_top #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [3:0] rsp_status,
   output logic [7:0] rsp_key_length,
   output logic [7:0] rsp_value_length
);
   import klp_pkg::*;

   item_type   req_item;
   item_type   stage_item;
   logic       stage_valid;
   logic       stage_take;
   logic       out_can_load;
   logic       core_result_valid;
   result_type core_result;
   result_type rsp_result;

   assign req_item.action    = req_action;
   assign req_item.text_byte = req_text_byte;

   klp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (req_item),
      .item_valid (stage_valid),
      .item       (stage_item),
      .item_take  (stage_take)
   );

   klp_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (stage_valid),
      .item         (stage_item),
      .item_take    (stage_take),
      .out_can_load (out_can_load),
      .result_valid (core_result_valid),
      .result       (core_result)
   );

   klp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (stage_take && core_result_valid),
      .load_result (core_result),
      .can_load    (out_can_load),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_result  (rsp_result)
   );

   assign rsp_kind         = rsp_result.kind;
   assign rsp_data         = rsp_result.data;
   assign rsp_status       = rsp_result.status;
   assign rsp_key_length   = rsp_result.key_length;
   assign rsp_value_length = rsp_result.value_length;

   // A byte the core cannot take yet must stay put in the input register.
   `KLP_ASSERT_NEXT(a_stage_hold, stage_valid && !stage_take,
      stage_valid && $stable(stage_item), "input register lost a stalled byte")

   `KLP_ASSERT_NOW(a_status_fields, rsp_valid && rsp_kind == KIND_STATUS,
      rsp_data == 8'd0, "status result carries nonzero data")

   `KLP_ASSERT_NOW(a_char_fields, rsp_valid && rsp_kind != KIND_STATUS,
      rsp_status == ST_OK && rsp_key_length == 8'd0 && rsp_value_length == 8'd0,
      "character result carries status or counts")

   `KLP_ASSERT_NOW(a_eof_counts, rsp_valid && rsp_status == ST_EOF,
      rsp_kind == KIND_STATUS && rsp_key_length == 8'd0 && rsp_value_length == 8'd0,
      "eof result is malformed")

endmodule
